// File: hdl/cchm_pkg.sv
`default_nettype none

package cchm_pkg;

	localparam int ADDRESS_BITS    = 32;
	localparam int COUNTER_BITS    = 32;
	localparam int MAX_BLOCKS_DEF  = 64;
	localparam int BLOCK_BYTES_DEF = 64;

	localparam int LOG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [LOG_W-1:0] SIZE_LOG2_MIN = 4'd7;
	localparam logic [LOG_W-1:0] SIZE_LOG2_MAX = 4'd12;
	localparam logic [LOG_W-1:0] SIZE_LOG2_RST = 4'd12;

	localparam logic [CFG_IDX_W-1:0] REG_MAPPING   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 2'd2;

	typedef struct packed {
		logic             assoc;
		logic             split;
		logic [LOG_W-1:0] size_log2;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic data;
	} res_t;

endpackage

`default_nettype wire

// File: hdl/cache_hit_miss_model_core.sv
`default_nettype none

// Cache tag-store model: each request (address, access_kind) taken on start while busy is
// low gives one result, shown for exactly one cycle with done high; the receiver cannot stall
// and must take it then. A direct-mapped lookup reads and compares the one indexed entry.
// A fully associative lookup reads the tag RAM one entry per cycle through one comparator
// and stops at the first hit, or after all n entries on a miss, where n is the number of
// blocks in the cache or half. A new request may be given in the cycle that shows the
// result. Valid bits sit in flip-flops, so no clearing pass follows reset.
// Configuration is written through cfg_valid/cfg_ready while busy is low; any write to a
// defined register invalidates all entries and keeps the counters. MAX_BLOCKS and BLOCK_BYTES
// must be powers of two.
module cache_hit_miss_model_core #(
	parameter int MAX_BLOCKS  = cchm_pkg::MAX_BLOCKS_DEF,
	parameter int BLOCK_BYTES = cchm_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [cchm_pkg::ADDRESS_BITS-1:0]  address,
	input  wire logic                               access_kind,
	output logic                                    done,
	output logic                                    hit,
	output logic      [cchm_pkg::COUNTER_BITS-1:0]  access_count,
	output logic      [cchm_pkg::COUNTER_BITS-1:0]  total_hits,
	output logic      [cchm_pkg::COUNTER_BITS-1:0]  data_hits,
	output logic      [cchm_pkg::COUNTER_BITS-1:0]  inst_hits,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cchm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cchm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = cchm_pkg::COUNTER_BITS;

	cchm_pkg::cfg_t cfg_q;
	cchm_pkg::res_t res;
	logic           eng_busy;
	logic           cfg_wr;
	logic           clear;
	logic           start_acc;
	logic           done_q;
	logic           hit_q;
	logic [CW-1:0]  acc_q;
	logic [CW-1:0]  tot_q;
	logic [CW-1:0]  dat_q;
	logic [CW-1:0]  ins_q;

	assign cfg_ready = !eng_busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign clear     = cfg_wr && ((cfg_index == cchm_pkg::REG_MAPPING) ||
		(cfg_index == cchm_pkg::REG_SPLIT) || (cfg_index == cchm_pkg::REG_SIZE_LOG2));
	assign start_acc = start && !eng_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.assoc     <= 1'b0;
			cfg_q.split     <= 1'b0;
			cfg_q.size_log2 <= cchm_pkg::SIZE_LOG2_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				cchm_pkg::REG_MAPPING:   cfg_q.assoc     <= cfg_data[0];
				cchm_pkg::REG_SPLIT:     cfg_q.split     <= cfg_data[0];
				cchm_pkg::REG_SIZE_LOG2: cfg_q.size_log2 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cchm_engine #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start_acc),
		.address     (address),
		.access_kind (access_kind),
		.cfg         (cfg_q),
		.clear       (clear),
		.busy        (eng_busy),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			acc_q  <= '0;
			tot_q  <= '0;
			dat_q  <= '0;
			ins_q  <= '0;
		end else begin
			done_q <= res.done;
			if (res.done) begin
				hit_q <= res.hit;
				acc_q <= acc_q + CW'(1);
				if (res.hit) begin
					tot_q <= tot_q + CW'(1);
					if (cfg_q.split && res.data) begin
						dat_q <= dat_q + CW'(1);
					end
					if (cfg_q.split && !res.data) begin
						ins_q <= ins_q + CW'(1);
					end
				end
			end
		end
	end

	assign busy         = eng_busy;
	assign done         = done_q;
	assign hit          = hit_q;
	assign access_count = acc_q;
	assign total_hits   = tot_q;
	assign data_hits    = dat_q;
	assign inst_hits    = ins_q;

endmodule

`default_nettype wire

// File: hdl/cchm_tag_ram.sv
`default_nettype none

module cchm_tag_ram #(
	parameter int DEPTH = cchm_pkg::MAX_BLOCKS_DEF,
	parameter int WIDTH = cchm_pkg::ADDRESS_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/cchm_engine.sv
`default_nettype none

module cchm_engine #(
	parameter int MAX_BLOCKS  = cchm_pkg::MAX_BLOCKS_DEF,
	parameter int BLOCK_BYTES = cchm_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [cchm_pkg::ADDRESS_BITS-1:0] address,
	input  wire logic                            access_kind,
	input  wire cchm_pkg::cfg_t                  cfg,
	input  wire logic                            clear,
	output logic                                 busy,
	output cchm_pkg::res_t                       res
);

	localparam int IDX_W    = $clog2(MAX_BLOCKS);
	localparam int CNT_W    = IDX_W + 1;
	localparam int BLK_LOG2 = $clog2(BLOCK_BYTES);
	localparam int TAG_W    = cchm_pkg::ADDRESS_BITS - BLK_LOG2;
	localparam int LW       = cchm_pkg::LOG_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [TAG_W-1:0]  blk_q;
	logic              kind_q;
	logic              fa_q;
	logic [IDX_W-1:0]  s_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_q;
	logic              vld_q;
	logic              hit_q;
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [IDX_W-1:0]  uptr_q;
	logic [IDX_W-1:0]  dptr_q;
	logic [IDX_W-1:0]  iptr_q;

	logic [LW-1:0]     lgc;
	logic [LW-1:0]     tlog_raw;
	logic [LW-1:0]     tlog;
	logic [CNT_W-1:0]  n_u;
	logic [CNT_W-1:0]  n_h;
	logic [CNT_W-1:0]  n_sel;
	logic [IDX_W-1:0]  base;
	logic [IDX_W-1:0]  mask;
	logic [TAG_W-1:0]  blk;
	logic [IDX_W-1:0]  ptr_sel;
	logic [CNT_W-1:0]  ptr_inc;
	logic [IDX_W-1:0]  ptr_next;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [TAG_W-1:0]  rd_data;
	logic              match;
	logic              last;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;

	always_comb begin
		if (cfg.size_log2 < cchm_pkg::SIZE_LOG2_MIN) begin
			lgc = cchm_pkg::SIZE_LOG2_MIN;
		end else if (cfg.size_log2 > cchm_pkg::SIZE_LOG2_MAX) begin
			lgc = cchm_pkg::SIZE_LOG2_MAX;
		end else begin
			lgc = cfg.size_log2;
		end
		if (lgc > LW'(BLK_LOG2 + 1)) begin
			tlog_raw = lgc - LW'(BLK_LOG2);
		end else begin
			tlog_raw = LW'(1);
		end
		if (tlog_raw > LW'(IDX_W)) begin
			tlog = LW'(IDX_W);
		end else begin
			tlog = tlog_raw;
		end
	end

	assign n_u   = CNT_W'(1) << tlog;
	assign n_h   = CNT_W'(1) << (tlog - LW'(1));
	assign n_sel = cfg.split ? n_h : n_u;
	assign base  = (cfg.split && !access_kind) ? n_h[IDX_W-1:0] : '0;
	assign mask  = IDX_W'(n_sel - CNT_W'(1));
	assign blk   = address[cchm_pkg::ADDRESS_BITS-1:BLK_LOG2];

	// single shared comparator, one stored tag per cycle
	assign rd_en   = (state_q == ST_SCAN) && (cnt_q < len_q);
	assign rd_addr = s_q + cnt_q[IDX_W-1:0];
	assign match   = pend_q && vld_q && (rd_data == blk_q);
	assign last    = pend_q && (cnt_q == len_q);
	assign wr_en   = (state_q == ST_SCAN) && last && !match;

	always_comb begin
		if (!cfg.split) begin
			ptr_sel = uptr_q;
		end else if (kind_q) begin
			ptr_sel = dptr_q;
		end else begin
			ptr_sel = iptr_q;
		end
	end

	assign ptr_inc  = {1'b0, ptr_sel} + CNT_W'(1);
	assign ptr_next = (ptr_inc == len_q) ? '0 : ptr_inc[IDX_W-1:0];
	assign wr_addr  = fa_q ? s_q + ptr_sel : s_q;

	cchm_tag_ram #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (TAG_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (blk_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_q <= rd_en;
					cnt_q  <= cnt_q + CNT_W'(rd_en);
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (last) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			blk_q  <= blk;
			kind_q <= access_kind;
			fa_q   <= cfg.assoc;
			if (cfg.assoc) begin
				s_q   <= base;
				len_q <= n_sel;
			end else begin
				s_q   <= base + (blk[IDX_W-1:0] & mask);
				len_q <= CNT_W'(1);
			end
		end
		if (rd_en) begin
			vld_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			uptr_q  <= '0;
			dptr_q  <= '0;
			iptr_q  <= '0;
		end else if (clear) begin
			valid_q <= '0;
			uptr_q  <= '0;
			dptr_q  <= '0;
			iptr_q  <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
			if (fa_q) begin
				if (!cfg.split) begin
					uptr_q <= ptr_next;
				end else if (kind_q) begin
					dptr_q <= ptr_next;
				end else begin
					iptr_q <= ptr_next;
				end
			end
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign res.done = (state_q == ST_DONE);
	assign res.hit  = hit_q;
	assign res.data = kind_q;

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("accepted request did not start a scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (state_q == ST_IDLE))
		else $error("result state held longer than one cycle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= len_q))
		else $error("scan issued more reads than entries");

	a_uptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, uptr_q} < n_u))
		else $error("unified replacement pointer out of range");

	a_half_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, dptr_q} < n_h) && ({1'b0, iptr_q} < n_h))
		else $error("split replacement pointer out of range");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;

	localparam int BLOCK_SHIFT = $clog2(cchm_pkg::BLOCK_BYTES_DEF);
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 40;
	localparam logic [cchm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int PTR_UNIFIED = 0;
	localparam int PTR_DATA    = 1;
	localparam int PTR_INST    = 2;

	typedef struct packed {
		logic                              hit;
		logic [cchm_pkg::COUNTER_BITS-1:0] accesses;
		logic [cchm_pkg::COUNTER_BITS-1:0] hits;
		logic [cchm_pkg::COUNTER_BITS-1:0] dhits;
		logic [cchm_pkg::COUNTER_BITS-1:0] ihits;
	} lookup_result_t;

	typedef struct {
		bit                                is_cfg;
		logic [cchm_pkg::CFG_IDX_W-1:0]    idx;
		logic [cchm_pkg::CFG_DATA_W-1:0]   data;
		logic [cchm_pkg::ADDRESS_BITS-1:0] addr;
		logic                              kind;
		int                                idle_pct;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [cchm_pkg::ADDRESS_BITS-1:0] address = '0;
	logic access_kind = 1'b0;
	logic cfg_valid = 1'b0;
	logic [cchm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cchm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic busy;
	logic done;
	logic hit;
	logic [cchm_pkg::COUNTER_BITS-1:0] access_count;
	logic [cchm_pkg::COUNTER_BITS-1:0] total_hits;
	logic [cchm_pkg::COUNTER_BITS-1:0] data_hits;
	logic [cchm_pkg::COUNTER_BITS-1:0] inst_hits;
	logic cfg_ready;

	cache_hit_miss_model_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.address      (address),
		.access_kind  (access_kind),
		.done         (done),
		.hit          (hit),
		.access_count (access_count),
		.total_hits   (total_hits),
		.data_hits    (data_hits),
		.inst_hits    (inst_hits),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	request_t       req_queue[$];
	lookup_result_t expected_lookups[$];

	cchm_pkg::cfg_t                    model_cfg;
	longint unsigned                   tag_mem[cchm_pkg::MAX_BLOCKS_DEF];
	bit                                valid_mem[cchm_pkg::MAX_BLOCKS_DEF];
	int                                fifo_ptr[3];
	logic [cchm_pkg::COUNTER_BITS-1:0] cnt_access;
	logic [cchm_pkg::COUNTER_BITS-1:0] cnt_hit;
	logic [cchm_pkg::COUNTER_BITS-1:0] cnt_dhit;
	logic [cchm_pkg::COUNTER_BITS-1:0] cnt_ihit;

	int issued = 0;
	int received = 0;
	int errors = 0;
	int hits_seen = 0;
	int cfg_writes = 0;
	int cycles = 0;

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		if (errors < PRINT_LIMIT)
			$display("[%0d] mismatch on %s: expected 0x%0h, got 0x%0h", cycles, what, want, got);
		errors++;
	endtask

	function automatic void invalidate_all();
		foreach (valid_mem[i])
			valid_mem[i] = 1'b0;
		foreach (fifo_ptr[i])
			fifo_ptr[i] = 0;
	endfunction

	function automatic void apply_cfg_write(input logic [cchm_pkg::CFG_IDX_W-1:0] idx,
			input logic [cchm_pkg::CFG_DATA_W-1:0] data);
		bit known;
		known = 1'b1;
		case (idx)
			cchm_pkg::REG_MAPPING:   model_cfg.assoc = data[0];
			cchm_pkg::REG_SPLIT:     model_cfg.split = data[0];
			cchm_pkg::REG_SIZE_LOG2: model_cfg.size_log2 = data;
			default:                 known = 1'b0;
		endcase
		if (known)
			invalidate_all();
	endfunction

	function automatic bit probe_tags(input longint unsigned blk, input int base, input int n,
			input int which);
		int idx;
		longint unsigned tag;
		if (!model_cfg.assoc) begin
			idx = base + int'(blk % longint'(n));
			tag = blk / longint'(n);
			if (valid_mem[idx] && tag_mem[idx] == tag)
				return 1'b1;
			tag_mem[idx] = tag;
			valid_mem[idx] = 1'b1;
			return 1'b0;
		end
		for (int i = 0; i < n; i++)
			if (valid_mem[base + i] && tag_mem[base + i] == blk)
				return 1'b1;
		if (fifo_ptr[which] >= n)
			fifo_ptr[which] = 0;
		tag_mem[base + fifo_ptr[which]] = blk;
		valid_mem[base + fifo_ptr[which]] = 1'b1;
		fifo_ptr[which]++;
		if (fifo_ptr[which] >= n)
			fifo_ptr[which] = 0;
		return 1'b0;
	endfunction

	function automatic int blocks_for(input logic [cchm_pkg::LOG_W-1:0] size_log2);
		int lg;
		int total;
		lg = size_log2;
		if (lg < cchm_pkg::SIZE_LOG2_MIN)
			lg = cchm_pkg::SIZE_LOG2_MIN;
		if (lg > cchm_pkg::SIZE_LOG2_MAX)
			lg = cchm_pkg::SIZE_LOG2_MAX;
		total = (1 << lg) >> BLOCK_SHIFT;
		if (total < 2)
			total = 2;
		if (total > cchm_pkg::MAX_BLOCKS_DEF)
			total = cchm_pkg::MAX_BLOCKS_DEF;
		return total;
	endfunction

	function automatic lookup_result_t predict_lookup(
			input logic [cchm_pkg::ADDRESS_BITS-1:0] addr, input logic kind);
		longint unsigned blk;
		int total;
		int n;
		bit h;
		lookup_result_t r;
		blk = longint'(addr) >> BLOCK_SHIFT;
		total = blocks_for(model_cfg.size_log2);
		cnt_access++;
		if (!model_cfg.split) begin
			h = probe_tags(blk, 0, total, PTR_UNIFIED);
		end else begin
			n = total / 2;
			if (kind) begin
				h = probe_tags(blk, 0, n, PTR_DATA);
				if (h)
					cnt_dhit++;
			end else begin
				h = probe_tags(blk, n, n, PTR_INST);
				if (h)
					cnt_ihit++;
			end
		end
		if (h)
			cnt_hit++;
		r.hit = h;
		r.accesses = cnt_access;
		r.hits = cnt_hit;
		r.dhits = cnt_dhit;
		r.ihits = cnt_ihit;
		return r;
	endfunction

	task automatic add_access(input logic [cchm_pkg::ADDRESS_BITS-1:0] addr, input logic kind,
			input int idle_pct);
		request_t q;
		q.is_cfg = 1'b0;
		q.idx = '0;
		q.data = '0;
		q.addr = addr;
		q.kind = kind;
		q.idle_pct = idle_pct;
		req_queue.push_back(q);
	endtask

	task automatic add_cfg(input logic [cchm_pkg::CFG_IDX_W-1:0] idx,
			input logic [cchm_pkg::CFG_DATA_W-1:0] data);
		request_t q;
		q.is_cfg = 1'b1;
		q.idx = idx;
		q.data = data;
		q.addr = '0;
		q.kind = 1'b0;
		q.idle_pct = 0;
		req_queue.push_back(q);
	endtask

	// driver: hold each request until the handshake, configure only when idle
	always @(posedge clk or negedge arst_n) begin
		request_t head;
		bit take_item;
		bit take_cfg;
		bit drive_start;
		bit drive_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			issued <= 0;
		end else begin
			take_item = start && !busy;
			take_cfg = cfg_valid && cfg_ready;
			if (take_item) begin
				expected_lookups.push_back(predict_lookup(address, access_kind));
				void'(req_queue.pop_front());
				issued <= issued + 1;
			end
			if (take_cfg) begin
				apply_cfg_write(cfg_index, cfg_data);
				void'(req_queue.pop_front());
				cfg_writes++;
			end
			drive_start = start && !take_item;
			drive_cfg = cfg_valid && !take_cfg;
			if (!drive_start && !drive_cfg && req_queue.size() > 0) begin
				head = req_queue[0];
				if (head.is_cfg) begin
					if (!take_item && issued == received && expected_lookups.size() == 0) begin
						drive_cfg = 1'b1;
						cfg_index <= head.idx;
						cfg_data <= head.data;
					end
				end else if ($urandom_range(99) >= head.idle_pct) begin
					drive_start = 1'b1;
					address <= head.addr;
					access_kind <= head.kind;
				end
			end
			start <= drive_start;
			cfg_valid <= drive_cfg;
		end
	end

	// monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && done) begin
			received <= received + 1;
			if (expected_lookups.size() == 0) begin
				report_mismatch("result with no request outstanding", 0, hit);
			end else begin
				want = expected_lookups.pop_front();
				if (hit)
					hits_seen++;
				if (hit !== want.hit)
					report_mismatch("hit", want.hit, hit);
				if (access_count !== want.accesses)
					report_mismatch("access_count", want.accesses, access_count);
				if (total_hits !== want.hits)
					report_mismatch("total_hits", want.hits, total_hits);
				if (data_hits !== want.dhits)
					report_mismatch("data_hits", want.dhits, data_hits);
				if (inst_hits !== want.ihits)
					report_mismatch("inst_hits", want.ihits, inst_hits);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int sizes[10];
		int idle_pct;
		int blocks;
		int cur_size;
		int r;
		logic [cchm_pkg::ADDRESS_BITS-1:0] base;
		logic [cchm_pkg::ADDRESS_BITS-1:0] addr;
		int wait_cycles;

		sizes = '{7, 12, 9, 0, 15, 8, 13, 10, 6, 11};
		model_cfg.assoc = 1'b0;
		model_cfg.split = 1'b0;
		model_cfg.size_log2 = cchm_pkg::SIZE_LOG2_RST;
		foreach (tag_mem[i])
			tag_mem[i] = 0;
		invalidate_all();
		cnt_access = '0;
		cnt_hit = '0;
		cnt_dhit = '0;
		cnt_ihit = '0;

		// reset configuration: direct mapped, unified, 64 blocks
		add_access(32'h0000_0000, 1'b0, 0);
		add_access(32'h0000_0000, 1'b1, 0);
		add_access(32'h0000_003F, 1'b0, 0);
		add_access(32'hFFFF_FFFF, 1'b1, 0);
		add_access(32'hFFFF_FFC0, 1'b0, 0);
		add_access(32'h0000_1000, 1'b1, 0);
		add_access(32'h0000_0000, 1'b0, 0);
		add_access(32'hAAAA_AAAA, 1'b1, 0);
		add_access(32'h5555_5555, 1'b0, 0);

		// smallest split, fully associative: one block per half
		add_cfg(cchm_pkg::REG_MAPPING, 4'b1011);
		add_cfg(cchm_pkg::REG_SPLIT, 4'b0101);
		add_cfg(cchm_pkg::REG_SIZE_LOG2, cchm_pkg::SIZE_LOG2_MIN);
		add_access(32'h0000_0000, 1'b1, 0);
		add_access(32'h0000_0000, 1'b0, 0);
		add_access(32'h0000_0010, 1'b1, 0);
		add_access(32'h0000_0020, 1'b0, 0);
		add_access(32'h0000_0040, 1'b1, 0);
		add_access(32'h0000_0000, 1'b1, 0);
		add_access(32'h0000_0000, 1'b0, 0);
		add_cfg(REG_UNUSED, 4'hF);
		add_access(32'h0000_0000, 1'b0, 0);
		add_access(32'h0000_0000, 1'b1, 0);

		cur_size = cchm_pkg::SIZE_LOG2_MIN;
		for (int p = 0; p < 10; p++) begin
			idle_pct = (p < 4) ? 34 : (p < 7) ? 46 : 0;
			if (p % 3 == 2) begin
				add_cfg(REG_UNUSED, 4'($urandom()));
			end else begin
				cur_size = sizes[p];
				add_cfg(cchm_pkg::REG_MAPPING, {3'($urandom()), 1'(p % 2)});
				add_cfg(cchm_pkg::REG_SPLIT, {3'($urandom()), 1'((p / 2) % 2)});
				add_cfg(cchm_pkg::REG_SIZE_LOG2, 4'(cur_size));
			end
			blocks = blocks_for(4'(cur_size));
			base = $urandom() & 32'hFFFF_F000;
			for (int k = 0; k < 55; k++) begin
				r = $urandom_range(99);
				if (r < 15)
					addr = $urandom();
				else
					addr = base + ($urandom_range(0, 3 * blocks - 1) << BLOCK_SHIFT)
						+ $urandom_range(0, cchm_pkg::BLOCK_BYTES_DEF - 1);
				add_access(addr, 1'($urandom()), (k >= 40) ? 0 : idle_pct);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() != 0 || start || cfg_valid)
			@(posedge clk);
		wait_cycles = 0;
		while (expected_lookups.size() != 0 && wait_cycles < 200) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (80) @(posedge clk);
		if (expected_lookups.size() != 0)
			report_mismatch("results never delivered", expected_lookups.size(), 0);

		$display("covered %0d lookups (%0d hits) across %0d register writes",
			received, hits_seen, cfg_writes);
		$display("modes: direct mapped and fully associative, unified and split, size codes in and out of range");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/cchm_pkg.sv
hdl/cchm_tag_ram.sv
hdl/cchm_engine.sv
hdl/cache_hit_miss_model_core.sv
test/tb_top.sv
